// ----- sv/kagome_heisenberg_matvec_core_defines.svh -----
// Assertion macros for the kagome matvec core.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef KAGOME_HEISENBERG_MATVEC_CORE_DEFINES_SVH
`define KAGOME_HEISENBERG_MATVEC_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define KMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmv assertion failed");

// Next-cycle implication, checked out of reset
`define KMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmv assertion failed");

`else

`define KMV_ASSERT_IMP(lbl, ante, cons)
`define KMV_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- sv/kmv_pkg.sv -----
package kmv_pkg;

  // Lattice geometry
  localparam int CELLS_X = 2;
  localparam int CELLS_Y = 2;
  localparam int SITES   = 3 * CELLS_X * CELLS_Y;
  localparam int DEPTH   = 1 << SITES;
  localparam int NBONDS  = 6 * CELLS_X * CELLS_Y;

  // Field and datapath widths
  localparam int AMP_W    = 32;
  localparam int CPL_W    = 24;
  localparam int PROD_W   = 48;
  localparam int BCNT_W   = $clog2(NBONDS);
  localparam int DIAG_W   = $clog2(NBONDS + 1) + 1;
  localparam int FLIP_W   = AMP_W + $clog2(NBONDS);
  localparam int TERM_W   = FLIP_W + 1;
  localparam int MUL_W    = CPL_W + TERM_W;
  localparam int OUT_SHIFT = 18;

  localparam logic signed [CPL_W-1:0] CPL_RESET = CPL_W'(65536);

  // Bond table: two-bit flip mask per bond
  typedef logic [SITES-1:0] site_mask_t;
  typedef site_mask_t bond_tbl_t [NBONDS];

  function automatic site_mask_t site_bit(int k);
    site_mask_t one;
    one = {{(SITES-1){1'b0}}, 1'b1};
    return one << k;
  endfunction

  function automatic bond_tbl_t build_bonds();
    bond_tbl_t tbl;
    int n, a, b, c, bm, cm;
    n = 0;
    for (int cx = 0; cx < CELLS_X; cx++) begin
      for (int cy = 0; cy < CELLS_Y; cy++) begin
        a  = 3 * (cx * CELLS_Y + cy);
        b  = a + 1;
        c  = a + 2;
        bm = 3 * (((cx + CELLS_X - 1) % CELLS_X) * CELLS_Y + cy) + 1;
        cm = 3 * (cx * CELLS_Y + ((cy + CELLS_Y - 1) % CELLS_Y)) + 2;
        tbl[n]     = site_bit(a)  | site_bit(b);
        tbl[n + 1] = site_bit(a)  | site_bit(c);
        tbl[n + 2] = site_bit(b)  | site_bit(c);
        tbl[n + 3] = site_bit(a)  | site_bit(bm);
        tbl[n + 4] = site_bit(a)  | site_bit(cm);
        tbl[n + 5] = site_bit(bm) | site_bit(cm);
        n = n + 6;
      end
    end
    return tbl;
  endfunction

  localparam bond_tbl_t BOND_MASK = build_bonds();

  // Microprogram addresses
  typedef logic [2:0] upc_t;
  localparam upc_t UPC_SELF  = 3'd0;
  localparam upc_t UPC_BOND  = 3'd1;
  localparam upc_t UPC_DRAIN = 3'd2;
  localparam upc_t UPC_SUM   = 3'd3;
  localparam upc_t UPC_MUL   = 3'd4;
  localparam upc_t UPC_OUT   = 3'd5;

  // Control word
  typedef struct packed {
    logic rd_self;  // read own amplitude, clear accumulators
    logic rd_bond;  // read bond-flipped amplitude, advance bond counter
    logic loop;     // stay on this step until the last bond
    logic do_sum;   // form D*x + 2F
    logic do_mul;   // multiply by J
    logic do_out;   // present result
    logic ret;      // return to idle
    upc_t nxt;      // next step
  } uword_t;

  // Microcode ROM
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = '0;
    case (a)
      UPC_SELF: begin
        w.rd_self = 1'b1;
        w.nxt     = UPC_BOND;
      end
      UPC_BOND: begin
        w.rd_bond = 1'b1;
        w.loop    = 1'b1;
        w.nxt     = UPC_DRAIN;
      end
      UPC_DRAIN: begin
        w.nxt = UPC_SUM;
      end
      UPC_SUM: begin
        w.do_sum = 1'b1;
        w.nxt    = UPC_MUL;
      end
      UPC_MUL: begin
        w.do_mul = 1'b1;
        w.nxt    = UPC_OUT;
      end
      UPC_OUT: begin
        w.do_out = 1'b1;
        w.ret    = 1'b1;
        w.nxt    = UPC_SELF;
      end
      default: begin
        w.ret = 1'b1;
        w.nxt = UPC_SELF;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/kagome_heisenberg_matvec_core.sv -----
// Channel   Handshake          Payload
// request   start / busy       in_mode, in_basis_index, in_amplitude
// result    out_valid strobe   out_product
// config    cfg_we             cfg_wdata (coupling J)
//
// A load leaves busy low, so loads can stream every cycle while busy is low.
// A query holds busy through one read of its own amplitude, 24 bond
// reads through the single read port of the vector memory, then drain, sum,
// multiply and output steps. out_valid pulses in the cycle in which busy falls.
// Synchronous active-low reset clears control and sets J to 1.0; the vector
// memory is not cleared. The result cannot be stalled.
`include "kagome_heisenberg_matvec_core_defines.svh"

module kagome_heisenberg_matvec_core import kmv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [SITES-1:0]         in_basis_index,
  input  logic signed [AMP_W-1:0]  in_amplitude,
  output logic                     out_valid,
  output logic signed [PROD_W-1:0] out_product,
  input  logic                     cfg_we,
  input  logic signed [CPL_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_st_t;

  seq_st_t                    st_r, st_nxt;
  upc_t                       upc_r, upc_nxt;
  logic [BCNT_W-1:0]          bcnt_r, bcnt_nxt;
  logic [SITES-1:0]           s_r;
  logic signed [CPL_W-1:0]    coupling_r;
  logic                       tag_self_r, tag_flip_r;
  logic signed [DIAG_W-1:0]   diag_r;
  logic signed [FLIP_W-1:0]   flip_r;
  logic signed [AMP_W-1:0]    x_self_r;
  logic signed [TERM_W-1:0]   term_r;
  logic signed [MUL_W-1:0]    mul_r;
  logic                       out_valid_r;
  logic signed [PROD_W-1:0]   out_product_r;

  uword_t                     uw;
  logic                       run;
  logic                       accept;
  logic                       last_bond;
  logic [SITES-1:0]           bmask;
  logic                       bond_diff;
  logic                       rd_en;
  logic [SITES-1:0]           rd_addr;
  logic [AMP_W-1:0]           rd_data;
  logic signed [AMP_W-1:0]    rd_amp;

  assign run       = (st_r == ST_RUN);
  assign busy      = run;
  assign accept    = start && !busy;
  assign uw        = ucode(upc_r);
  assign last_bond = (bcnt_r == BCNT_W'(NBONDS - 1));
  assign bmask     = BOND_MASK[bcnt_r];
  assign bond_diff = ^(s_r & bmask);
  assign rd_amp    = $signed(rd_data);

  // Sequencer: step counter with loop on the bond step
  always_comb begin
    st_nxt   = st_r;
    upc_nxt  = upc_r;
    bcnt_nxt = bcnt_r;
    case (st_r)
      ST_IDLE: begin
        if (accept && in_mode) begin
          st_nxt  = ST_RUN;
          upc_nxt = UPC_SELF;
        end
      end
      ST_RUN: begin
        if (uw.rd_self) begin
          bcnt_nxt = '0;
        end else if (uw.rd_bond && !last_bond) begin
          bcnt_nxt = bcnt_r + 1'b1;
        end
        if (uw.loop && !last_bond) begin
          upc_nxt = upc_r;
        end else begin
          upc_nxt = uw.nxt;
        end
        if (uw.ret) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt  = ST_IDLE;
        upc_nxt = UPC_SELF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      upc_r  <= UPC_SELF;
      bcnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      upc_r  <= upc_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  // Coupling register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r <= CPL_RESET;
    end else if (cfg_we) begin
      coupling_r <= cfg_wdata;
    end
  end

  // Latch the query index
  always_ff @(posedge clk) begin
    if (accept && in_mode) begin
      s_r <= in_basis_index;
    end
  end

  // Vector memory: loads write, the program reads
  assign rd_en   = run && (uw.rd_self || uw.rd_bond);
  assign rd_addr = uw.rd_self ? s_r : (s_r ^ bmask);

  kmv_ram #(
    .WIDTH (AMP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && !in_mode),
    .waddr (in_basis_index),
    .wdata (in_amplitude),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Tag each read so its data is routed the cycle it returns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_self_r <= 1'b0;
      tag_flip_r <= 1'b0;
    end else begin
      tag_self_r <= run && uw.rd_self;
      tag_flip_r <= run && uw.rd_bond && bond_diff;
    end
  end

  // Bond sign count: start at all-equal, drop two per differing bond
  always_ff @(posedge clk) begin
    if (run && uw.rd_self) begin
      diag_r <= DIAG_W'(NBONDS);
    end else if (run && uw.rd_bond && bond_diff) begin
      diag_r <= diag_r - DIAG_W'(2);
    end
  end

  // Own amplitude and flipped-amplitude sum
  always_ff @(posedge clk) begin
    if (run && uw.rd_self) begin
      flip_r <= '0;
    end else if (tag_flip_r) begin
      flip_r <= flip_r + FLIP_W'(rd_amp);
    end
    if (tag_self_r) begin
      x_self_r <= rd_amp;
    end
  end

  // Sum and multiply steps
  always_ff @(posedge clk) begin
    if (run && uw.do_sum) begin
      term_r <= TERM_W'(diag_r) * TERM_W'(x_self_r) + (TERM_W'(flip_r) <<< 1);
    end
    if (run && uw.do_mul) begin
      mul_r <= MUL_W'(coupling_r) * MUL_W'(term_r);
    end
  end

  // Output strobe and scaled result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= run && uw.do_out;
    end
  end

  always_ff @(posedge clk) begin
    if (run && uw.do_out) begin
      out_product_r <= PROD_W'(mul_r >>> OUT_SHIFT);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;

  // Checks
  `KMV_ASSERT_IMP(a_out_after_step, out_valid_r, $past(run && upc_r == UPC_OUT))
  `KMV_ASSERT_NXT(a_query_starts, accept && in_mode, busy && upc_r == UPC_SELF)
  `KMV_ASSERT_IMP(a_tags_exclusive, tag_self_r, !tag_flip_r)
  `KMV_ASSERT_IMP(a_bcnt_range, busy, bcnt_r <= BCNT_W'(NBONDS - 1))
  `KMV_ASSERT_NXT(a_load_no_busy, accept && !in_mode, !busy)

endmodule

// ----- sv/kmv_ram.sv -----
module kmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
